>>> hdl/aes128_pkg.sv
// Package: types, constants and round functions for the AES-128 engine.
`timescale 1ns / 1ps
package aes128_pkg;

   localparam int ROUNDS_DEF = 10;
   localparam int BLOCK_W    = 128;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_ENCRYPT = 2'd1,
      CMD_DECRYPT = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ROUND = 2'd1,
      ST_HOLD  = 2'd2
   } eng_state_type;

   typedef struct packed {
      logic         inverse;
      logic         last;
      logic [127:0] data;
   } job_type;

   function automatic logic [7:0] fwd_sbox(input logic [7:0] v);
      logic [7:0] r;
      unique case (v)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      endcase
      return r;
   endfunction

   // Inverse S-box found by searching the forward table for the input that maps to v.
   function automatic logic [7:0] inv_sbox(input logic [7:0] v);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 256; i++) begin
         if (fwd_sbox(8'(i)) == v) begin
            r = 8'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] enc_shift_sub(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(r+4*c) +: 8] = fwd_sbox(s[8*(r+4*((c+r)%4)) +: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] dec_shift_sub(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(r+4*c) +: 8] = inv_sbox(s[8*(r+4*((c-r+4)%4)) +: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] enc_mix(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[32*c +: 8];
         a1 = s[32*c+8 +: 8];
         a2 = s[32*c+16 +: 8];
         a3 = s[32*c+24 +: 8];
         t[32*c +: 8]    = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[32*c+8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[32*c+16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[32*c+24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return t;
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] p, x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) begin
            p = p ^ x;
         end
         x = xtime(x);
      end
      return p;
   endfunction

   function automatic logic [127:0] dec_mix(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[32*c +: 8];
         a1 = s[32*c+8 +: 8];
         a2 = s[32*c+16 +: 8];
         a3 = s[32*c+24 +: 8];
         t[32*c +: 8]    = gmul(a0,4'd14) ^ gmul(a1,4'd11) ^ gmul(a2,4'd13) ^ gmul(a3,4'd9);
         t[32*c+8 +: 8]  = gmul(a0,4'd9) ^ gmul(a1,4'd14) ^ gmul(a2,4'd11) ^ gmul(a3,4'd13);
         t[32*c+16 +: 8] = gmul(a0,4'd13) ^ gmul(a1,4'd9) ^ gmul(a2,4'd14) ^ gmul(a3,4'd11);
         t[32*c+24 +: 8] = gmul(a0,4'd11) ^ gmul(a1,4'd13) ^ gmul(a2,4'd9) ^ gmul(a3,4'd14);
      end
      return t;
   endfunction

endpackage

>>> hdl/aes128_front.sv
// Front end: takes commands, writes round keys, queues block jobs.
`timescale 1ns / 1ps
module aes128_front #(
   parameter int ROUNDS = aes128_pkg::ROUNDS_DEF,
   parameter int SLOT_W = $clog2(ROUNDS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_command,
   input  logic [3:0]            req_key_slot,
   input  logic [63:0]           req_block_hi,
   input  logic [63:0]           req_block_lo,
   input  logic                  req_last_block,
   input  logic                  engine_busy,
   output logic                  key_wr_en,
   output logic [SLOT_W-1:0]     key_wr_slot,
   output logic [127:0]          key_wr_data,
   output logic                  job_valid,
   input  logic                  job_take,
   output aes128_pkg::job_type   job
);
   import aes128_pkg::*;

   localparam int QW = $clog2(QUEUE_DEPTH);

   job_type          q_mem [QUEUE_DEPTH];
   logic [QW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QW:0]      count_ff, count_in;
   logic             accept, is_block, push, pop;
   cmd_type          cmd;

   assign cmd       = cmd_type'(req_command);
   // a key load waits until no queued or running block can still read the store
   assign req_stall = (count_ff == (QW+1)'(QUEUE_DEPTH)) ||
                      ((cmd == CMD_LOAD) && ((count_ff != '0) || engine_busy));
   assign accept    = req_valid && !req_stall;
   assign is_block  = (cmd == CMD_ENCRYPT) || (cmd == CMD_DECRYPT);
   assign push      = accept && is_block;
   assign pop       = job_take && (count_ff != '0);

   assign key_wr_en   = accept && (cmd == CMD_LOAD) && ({28'd0, req_key_slot} <= 32'(ROUNDS));
   assign key_wr_slot = SLOT_W'(req_key_slot);
   assign key_wr_data = {req_block_hi, req_block_lo};

   assign job_valid = (count_ff != '0);
   assign job       = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + (QW+1)'(push) - (QW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= '{inverse: (cmd == CMD_DECRYPT), last: req_last_block,
                               data: {req_block_hi, req_block_lo}};
      end
   end

endmodule

>>> hdl/aes128_engine.sv
// Back end: round key store and iterative one-round-per-cycle datapath.
`timescale 1ns / 1ps
module aes128_engine #(
   parameter int ROUNDS = aes128_pkg::ROUNDS_DEF,
   parameter int SLOT_W = $clog2(ROUNDS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  key_wr_en,
   input  logic [SLOT_W-1:0]     key_wr_slot,
   input  logic [127:0]          key_wr_data,
   input  logic                  job_valid,
   output logic                  job_take,
   input  aes128_pkg::job_type   job,
   output logic                  engine_busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [63:0]           rsp_result_hi,
   output logic [63:0]           rsp_result_lo,
   output logic                  rsp_end_of_run
);
   import aes128_pkg::*;

   logic [127:0]      key_mem [ROUNDS+1];
   logic [127:0]      key_rd_ff;
   logic [SLOT_W-1:0] rd_slot;
   eng_state_type     state_ff, state_in;
   logic [SLOT_W-1:0] rnd_ff, rnd_in;
   logic [127:0]      data_ff, data_in, ss, rnd_out;
   logic              inv_ff, inv_in, last_ff, last_in;

   // Key for the next round is registered in the cycle before that round uses it.
   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_mem[key_wr_slot] <= key_wr_data;
      end
      key_rd_ff <= key_mem[rd_slot];
   end

   assign ss      = inv_ff ? dec_shift_sub(data_ff) : enc_shift_sub(data_ff);
   assign rnd_out = ((rnd_ff == SLOT_W'(ROUNDS)) ? ss
                     : (inv_ff ? dec_mix(ss) : enc_mix(ss))) ^ key_rd_ff;

   assign engine_busy    = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_HOLD);
   assign rsp_result_hi  = data_ff[127:64];
   assign rsp_result_lo  = data_ff[63:0];
   assign rsp_end_of_run = last_ff;

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      data_in  = data_ff;
      inv_in   = inv_ff;
      last_in  = last_ff;
      job_take = 1'b0;
      rd_slot  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            // Key 0 is read this cycle; whitening happens on the first round cycle.
            if (job_valid) begin
               job_take = 1'b1;
               data_in  = job.data;
               inv_in   = job.inverse;
               last_in  = job.last;
               rnd_in   = '0;
               rd_slot  = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            data_in = (rnd_ff == '0) ? (data_ff ^ key_rd_ff) : rnd_out;
            rnd_in  = SLOT_W'(rnd_ff + 1'b1);
            if (rnd_ff == SLOT_W'(ROUNDS)) begin
               state_in = ST_HOLD;
            end else begin
               rd_slot = SLOT_W'(rnd_ff + 1'b1);
            end
         end
         ST_HOLD: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      inv_ff  <= inv_in;
      last_ff <= last_in;
   end

endmodule

>>> hdl/aes128_block_cipher_top.sv
// Top level of the AES-128 ECB engine on pre-expanded round keys.
//
// Request channel (req_*): command 0 loads block_hi/block_lo as round key
// key_slot (0..ROUNDS, higher slots ignored); command 1 encrypts and
// command 2 decrypts the block (decrypt expects the equivalent inverse key
// schedule); command 3 is dropped. Loads and dropped commands give no
// response. A transfer happens when req_valid is high and req_stall low.
// Block commands pass a two-entry queue to the round engine, which does
// one round per cycle. Idle, it takes a block from the queue, whitens it,
// runs the rounds and holds the result on rsp_valid; its single round
// unit serves one block at a time, so it takes no new block until idle.
// rsp_valid holds with a stable payload while rsp_stall is high; the
// queue keeps accepting until full, then raises req_stall.
// A load is held off with req_stall until the queue is empty and the
// engine idle, so each block uses the keys loaded before it.
// Reset clears the queue and engine control; the key store is not
// cleared and each slot must be loaded before a block uses it.
`timescale 1ns / 1ps
module aes128_block_cipher_top #(
   parameter int ROUNDS = aes128_pkg::ROUNDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_key_slot,
   input  logic [63:0] req_block_hi,
   input  logic [63:0] req_block_lo,
   input  logic        req_last_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_hi,
   output logic [63:0] rsp_result_lo,
   output logic        rsp_end_of_run
);
   import aes128_pkg::*;

   localparam int SLOT_W = $clog2(ROUNDS + 1);

   logic              key_wr_en, job_valid, job_take, engine_busy;
   logic [SLOT_W-1:0] key_wr_slot;
   logic [127:0]      key_wr_data;
   job_type           job;

   aes128_front #(.ROUNDS(ROUNDS), .SLOT_W(SLOT_W)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_key_slot,
      .req_block_hi, .req_block_lo, .req_last_block, .engine_busy,
      .key_wr_en, .key_wr_slot, .key_wr_data, .job_valid, .job_take, .job
   );

   aes128_engine #(.ROUNDS(ROUNDS), .SLOT_W(SLOT_W)) u_engine (
      .clock, .reset, .key_wr_en, .key_wr_slot, .key_wr_data,
      .job_valid, .job_take, .job, .engine_busy,
      .rsp_valid, .rsp_stall, .rsp_result_hi, .rsp_result_lo, .rsp_end_of_run
   );

endmodule

>>> bench/aes128_block_cipher_top_tb.sv
// Self-checking testbench for the AES-128 ECB engine: round key loads and block transfers.
`timescale 1ns / 1ps
module aes128_block_cipher_top_tb;
   import aes128_pkg::*;

   localparam int NUM_KEYS   = ROUNDS_DEF + 1;
   localparam int IDLE_LIMIT = 5000;
   localparam int MAX_SHOWN  = 10;

   localparam logic [2047:0] SUB_TAB = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
   };

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
      logic        last;
   } cipher_out_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_LOAD;
   logic [3:0]  req_key_slot = 4'd0;
   logic [63:0] req_block_hi = 64'd0;
   logic [63:0] req_block_lo = 64'd0;
   logic        req_last_block = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_result_hi;
   logic [63:0] rsp_result_lo;
   logic        rsp_end_of_run;

   logic [127:0] round_keys [NUM_KEYS];
   logic [7:0]   inv_tab [256];
   cipher_out_t  predicted_blocks [$];
   int           tx_idle_pct = 0;
   int           rx_idle_pct = 0;
   int           mismatches = 0;
   int           idle_cycles = 0;

   aes128_block_cipher_top uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [7:0] sub_fwd(input logic [7:0] v);
      return SUB_TAB[2047 - 8 * v -: 8];
   endfunction

   function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return p;
   endfunction

   function automatic logic [127:0] aes_transform(input logic [127:0] blk, input bit inv);
      logic [127:0] s, t;
      logic [7:0]   co [4];
      logic [7:0]   acc, v;
      int           src;
      if (inv) co = '{8'd14, 8'd11, 8'd13, 8'd9};
      else co = '{8'd2, 8'd3, 8'd1, 8'd1};
      s = blk ^ round_keys[0];
      for (int rnd = 1; rnd <= ROUNDS_DEF; rnd++) begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
               v = s[8 * (r + 4 * src) +: 8];
               t[8 * (r + 4 * c) +: 8] = inv ? inv_tab[v] : sub_fwd(v);
            end
         end
         if (rnd < ROUNDS_DEF) begin
            for (int c = 0; c < 4; c++) begin
               for (int r = 0; r < 4; r++) begin
                  acc = 8'h00;
                  for (int j = 0; j < 4; j++)
                     acc ^= gf_mult(t[8 * (4 * c + j) +: 8], co[(j - r + 4) & 3]);
                  s[8 * (4 * c + r) +: 8] = acc;
               end
            end
         end else begin
            s = t;
         end
         s = s ^ round_keys[rnd];
      end
      return s;
   endfunction

   task automatic send_item(input cmd_type cmd, input logic [3:0] slot,
                            input logic [63:0] hi, input logic [63:0] lo, input logic last);
      logic [127:0] res;
      if ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_key_slot   <= slot;
      req_block_hi   <= hi;
      req_block_lo   <= lo;
      req_last_block <= last;
      do @(posedge clock); while (req_stall);
      case (cmd)
         CMD_LOAD: if (slot < NUM_KEYS) round_keys[slot] = {hi, lo};
         CMD_ENCRYPT, CMD_DECRYPT: begin
            res = aes_transform({hi, lo}, cmd == CMD_DECRYPT);
            predicted_blocks.push_back('{res[127:64], res[63:0], last});
         end
         default: ;
      endcase
   endtask

   task automatic drain;
      @(negedge clock) req_valid <= 1'b0;
      wait (predicted_blocks.size() == 0);
   endtask

   task automatic test_key_load;
      send_item(CMD_LOAD, 4'd0, 64'd0, 64'd0, 1'b1);
      for (int k = 1; k < NUM_KEYS - 1; k++)
         send_item(CMD_LOAD, 4'(k), {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      send_item(CMD_LOAD, 4'(NUM_KEYS - 1), '1, '1, 1'b0);
   endtask

   task automatic test_ignored_items;
      // out-of-range slots must not touch the store; unused command gives nothing
      send_item(CMD_LOAD, 4'(NUM_KEYS), 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
      send_item(CMD_LOAD, 4'd15, '1, 64'd0, 1'b1);
      send_item(CMD_UNUSED, 4'd3, '1, '1, 1'b1);
      send_item(CMD_ENCRYPT, 4'd15, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
   endtask

   task automatic test_block_edges;
      for (int op = 0; op < 2; op++) begin
         cmd_type cmd;
         cmd = op ? CMD_DECRYPT : CMD_ENCRYPT;
         send_item(cmd, 4'd0, 64'd0, 64'd0, 1'b0);
         send_item(cmd, 4'd15, '1, '1, 1'b1);
         send_item(cmd, 4'd10, 64'h8000000000000000, 64'd1, 1'b1);
         send_item(cmd, 4'd7, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      end
   endtask

   task automatic test_random(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 8)
            send_item(CMD_LOAD, 4'($urandom_range(15)), {$urandom, $urandom},
                      {$urandom, $urandom}, 1'($urandom));
         else if (pick < 11)
            send_item(CMD_UNUSED, 4'($urandom), {$urandom, $urandom},
                      {$urandom, $urandom}, 1'($urandom));
         else
            send_item(pick & 1 ? CMD_ENCRYPT : CMD_DECRYPT, 4'($urandom),
                      {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
      end
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < rx_idle_pct);

   always @(posedge clock) begin
      cipher_out_t want;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL aes128_block_cipher_top");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_blocks.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) $display("unexpected transfer %h_%h", rsp_result_hi,
                                                  rsp_result_lo);
         end else begin
            want = predicted_blocks.pop_front();
            if (rsp_result_hi !== want.hi || rsp_result_lo !== want.lo ||
                rsp_end_of_run !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("mismatch: exp %h_%h last %b, got %h_%h last %b", want.hi, want.lo,
                           want.last, rsp_result_hi, rsp_result_lo, rsp_end_of_run);
            end
         end
      end
   end

   initial begin
      for (int v = 0; v < 256; v++) inv_tab[sub_fwd(8'(v))] = 8'(v);
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      tx_idle_pct = 21;
      rx_idle_pct = 45;
      test_key_load();
      test_ignored_items();
      test_block_edges();
      test_random(650);
      drain();
      tx_idle_pct = 45;
      rx_idle_pct = 21;
      test_random(650);
      drain();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random(650);
      drain();
      repeat (30) @(posedge clock);
      if (mismatches == 0 && predicted_blocks.size() == 0)
         $display("PASS aes128_block_cipher_top");
      else
         $display("FAIL aes128_block_cipher_top");
      $finish;
   end

endmodule
